// File: design/tex_catcode_tokenizer_assert.svh
// Assertion macros for the catcode tokenizer.
`ifndef TEX_CATCODE_TOKENIZER_ASSERT_SVH
`define TEX_CATCODE_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define TCT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tct: assertion failed");
// Checked at every edge, reset included.
`define TCT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tct: assertion failed");
`else
`define TCT_ASSERT(lbl, prop)
`define TCT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: design/tct_pkg.sv
// Types, constants and helpers shared by the catcode tokenizer modules.
package tct_pkg;

   localparam int COUNT_W = 25;
   localparam int unsigned MAX_STREAM_BYTES_DEF = 32'd16777216;
   localparam logic [COUNT_W-1:0] TOKEN_LIMIT_RESET = 25'h1000000;

   // result slots filled by one byte, in output order
   localparam int SLOTS       = 4;
   localparam int SLOT_ESC_A  = 0;   // escape closed by a non-letter
   localparam int SLOT_TOKEN  = 1;   // ordinary single-byte token
   localparam int SLOT_ESC_C  = 2;   // escape still open at stream end
   localparam int SLOT_END    = 3;   // end record
   localparam int MAX_RESULTS = 3;

   // token kinds
   localparam logic [3:0] KIND_ESCAPE  = 4'd0;
   localparam logic [3:0] KIND_OPEN    = 4'd1;
   localparam logic [3:0] KIND_CLOSE   = 4'd2;
   localparam logic [3:0] KIND_DOLLAR  = 4'd3;
   localparam logic [3:0] KIND_NEWLINE = 4'd5;
   localparam logic [3:0] KIND_SPACE   = 4'd10;
   localparam logic [3:0] KIND_LETTER  = 4'd11;
   localparam logic [3:0] KIND_OTHER   = 4'd12;

   // special bytes
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'b0001,
      MODE_ESCAPE  = 4'b0010,
      MODE_COMMENT = 4'b0100,
      MODE_STOPPED = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [COUNT_W-1:0] byte_off;
      logic [COUNT_W-1:0] line;
      logic [COUNT_W-1:0] col;
      logic [COUNT_W-1:0] esc_off;
      logic [COUNT_W-1:0] esc_col;
      logic [COUNT_W-1:0] tok;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:     MODE_NORMAL,
      byte_off: '0,
      line:     25'd1,
      col:      25'd1,
      esc_off:  '0,
      esc_col:  25'd1,
      tok:      '0
   };

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         char_code;
      logic [COUNT_W-1:0] start_offset;
      logic [COUNT_W-1:0] end_offset;
      logic [COUNT_W-1:0] line_no;
      logic [COUNT_W-1:0] column_no;
      logic [COUNT_W-1:0] token_index;
      logic               is_end_record;
   } result_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
             ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
   endfunction

   // kind of a byte that forms a token of its own
   function automatic logic [3:0] kind_of(input logic [7:0] b);
      logic [3:0] k;
      case (b) inside
         CH_LBRACE:                 k = KIND_OPEN;
         CH_RBRACE:                 k = KIND_CLOSE;
         CH_DOLLAR:                 k = KIND_DOLLAR;
         CH_NEWLINE:                k = KIND_NEWLINE;
         CH_SPACE, CH_TAB:          k = KIND_SPACE;
         [CH_UPPER_A:CH_UPPER_Z],
         [CH_LOWER_A:CH_LOWER_Z]:   k = KIND_LETTER;
         default:                   k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

// File: design/tct_step.sv
// Per-byte scan logic: next state and up to three result records.
module tct_step #(
   parameter int unsigned MAX_STREAM_BYTES = tct_pkg::MAX_STREAM_BYTES_DEF
) (
   input  tct_pkg::state_type                       cur_state,
   input  logic [7:0]                               data_byte,
   input  logic                                     final_byte,
   input  logic [tct_pkg::COUNT_W-1:0]              token_limit,
   output tct_pkg::state_type                       next_state,
   output tct_pkg::result_type [tct_pkg::SLOTS-1:0] results,
   output logic [tct_pkg::SLOTS-1:0]                result_valid
);
   import tct_pkg::*;

   localparam longint unsigned CapMax  = (64'd1 << COUNT_W) - 64'd1;
   localparam longint unsigned CapWide =
      (longint'(MAX_STREAM_BYTES) < CapMax) ? longint'(MAX_STREAM_BYTES) : CapMax;
   localparam logic [COUNT_W-1:0] SatCap = COUNT_W'(CapWide);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v < SatCap) ? v + 1'b1 : v;
   endfunction

   state_type          st;
   logic               do_normal;
   logic               letter;
   logic [COUNT_W-1:0] off_inc;
   logic [COUNT_W-1:0] col_inc;
   logic [COUNT_W-1:0] line_inc;
   logic [COUNT_W-1:0] tok_p1;

   assign off_inc  = sat_inc(cur_state.byte_off);
   assign col_inc  = sat_inc(cur_state.col);
   assign line_inc = sat_inc(cur_state.line);
   assign tok_p1   = cur_state.tok + 1'b1;
   assign letter   = is_letter(data_byte);

   always_comb begin
      st           = cur_state;
      results      = '0;
      result_valid = '0;
      do_normal    = 1'b0;

      case (cur_state.mode)
         MODE_ESCAPE: begin
            if (letter) begin
               st.byte_off = off_inc;
               st.col      = col_inc;
            end else begin
               results[SLOT_ESC_A] = '{
                  kind: KIND_ESCAPE, char_code: '0,
                  start_offset: cur_state.esc_off, end_offset: cur_state.byte_off,
                  line_no: cur_state.line, column_no: cur_state.esc_col,
                  token_index: cur_state.tok, is_end_record: 1'b0};
               result_valid[SLOT_ESC_A] = 1'b1;
               st.tok = tok_p1;
               if (tok_p1 >= token_limit) begin
                  st.mode = MODE_STOPPED;
               end else begin
                  st.mode   = MODE_NORMAL;
                  do_normal = 1'b1;
               end
            end
         end
         MODE_COMMENT: begin
            if (data_byte == CH_NEWLINE) begin
               st.mode   = MODE_NORMAL;
               do_normal = 1'b1;
            end else begin
               st.byte_off = off_inc;
               st.col      = col_inc;
            end
         end
         MODE_NORMAL: do_normal = 1'b1;
         default: ;
      endcase

      if (do_normal) begin
         if ((st.tok >= token_limit) || (data_byte == CH_NUL)) begin
            st.mode = MODE_STOPPED;
         end else if (data_byte == CH_BACKSLASH) begin
            st.esc_off  = cur_state.byte_off;
            st.esc_col  = cur_state.col;
            st.byte_off = off_inc;
            st.col      = col_inc;
            st.mode     = MODE_ESCAPE;
         end else if (data_byte == CH_PERCENT) begin
            st.byte_off = off_inc;
            st.col      = col_inc;
            st.mode     = MODE_COMMENT;
         end else begin
            results[SLOT_TOKEN] = '{
               kind: kind_of(data_byte), char_code: data_byte,
               start_offset: cur_state.byte_off, end_offset: off_inc,
               line_no: cur_state.line, column_no: cur_state.col,
               token_index: st.tok, is_end_record: 1'b0};
            result_valid[SLOT_TOKEN] = 1'b1;
            st.byte_off = off_inc;
            if (data_byte == CH_NEWLINE) begin
               st.line = line_inc;
               st.col  = 25'd1;
            end else begin
               st.col = col_inc;
            end
            st.tok = st.tok + 1'b1;
            if (st.tok >= token_limit) begin
               st.mode = MODE_STOPPED;
            end
         end
      end

      if (final_byte) begin
         if (st.mode == MODE_ESCAPE) begin
            results[SLOT_ESC_C] = '{
               kind: KIND_ESCAPE, char_code: '0,
               start_offset: st.esc_off, end_offset: st.byte_off,
               line_no: st.line, column_no: st.esc_col,
               token_index: st.tok, is_end_record: 1'b0};
            result_valid[SLOT_ESC_C] = 1'b1;
            st.tok = st.tok + 1'b1;
         end
         results[SLOT_END] = '{
            kind: KIND_ESCAPE, char_code: '0,
            start_offset: st.byte_off, end_offset: st.byte_off,
            line_no: st.line, column_no: st.col,
            token_index: st.tok, is_end_record: 1'b1};
         result_valid[SLOT_END] = 1'b1;
         st = STATE_RESET;
      end

      next_state = st;
   end

endmodule

// File: design/tct_rsp_buf.sv
// Result register: holds the records of one byte and drains them one per transfer.
`include "tex_catcode_tokenizer_assert.svh"
module tct_rsp_buf (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  tct_pkg::result_type [tct_pkg::SLOTS-1:0] results,
   input  logic [tct_pkg::SLOTS-1:0]                result_valid,
   output logic                                     can_load,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output tct_pkg::result_type                      rsp_data,
   output logic                                     rsp_last_of_run
);
   import tct_pkg::*;

   result_type [SLOTS-1:0] slots_ff;
   logic [SLOTS-1:0]       mask_ff;
   logic [SLOTS-1:0]       mask_in;
   logic [SLOTS-1:0]       sel_oh;
   logic [SLOTS-1:0]       rest;
   logic                   take;

   // lowest pending slot goes out first
   assign sel_oh          = mask_ff & (~mask_ff + 1'b1);
   assign rest            = mask_ff & ~sel_oh;
   assign rsp_valid       = |mask_ff;
   assign rsp_last_of_run = (rest == '0);
   assign take            = rsp_valid && !rsp_stall;
   assign can_load        = !rsp_valid || (take && rsp_last_of_run);

   always_comb begin
      rsp_data = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sel_oh[i]) begin
            rsp_data = slots_ff[i];
         end
      end
   end

   always_comb begin
      if (load) begin
         mask_in = result_valid;
      end else if (take) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= results;
      end
   end

   `TCT_ASSERT(a_run_bounded, $countones(mask_ff) <= MAX_RESULTS)
   `TCT_ASSERT(a_end_closes_run, (rsp_valid && rsp_data.is_end_record) |-> rsp_last_of_run)
   `TCT_ASSERT(a_no_overwrite, load |-> (!rsp_valid || (take && rsp_last_of_run)))

endmodule

// File: design/tex_catcode_tokenizer.sv
// Top level of the catcode tokenizer: input register, scan state, result register.
//
//  channel | ports                              | dir | flow control
//  --------+------------------------------------+-----+---------------------
//  req     | req_data_byte, req_final_byte      | in  | req_valid / req_stall
//  rsp     | rsp_kind .. rsp_last_of_run        | out | rsp_valid / rsp_stall
//  csr     | csr_token_limit                    | in  | csr_valid / csr_ready
//
//  One byte per cycle through the scan logic while req_stall is low; a byte yields
//  zero to three records, and the result register drains one record per rsp
//  transfer, so a byte with n records occupies the output for n transfers.
//  req_stall rises only while the input register holds a byte and the result
//  register still has records that will not be gone after this cycle.
//  Reset is synchronous: mode normal, offset 0, line and column 1, token
//  count 0, token limit 2^24; both registers empty.
//  csr_ready is high only while no byte or record is held.
`include "tex_catcode_tokenizer_assert.svh"
module tex_catcode_tokenizer #(
   parameter int unsigned MAX_STREAM_BYTES = tct_pkg::MAX_STREAM_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // byte input
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_final_byte,
   // token records
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_kind,
   output logic [7:0]                  rsp_char_code,
   output logic [tct_pkg::COUNT_W-1:0] rsp_start_offset,
   output logic [tct_pkg::COUNT_W-1:0] rsp_end_offset,
   output logic [tct_pkg::COUNT_W-1:0] rsp_line_no,
   output logic [tct_pkg::COUNT_W-1:0] rsp_column_no,
   output logic [tct_pkg::COUNT_W-1:0] rsp_token_index,
   output logic                        rsp_is_end_record,
   output logic                        rsp_last_of_run,
   // token limit register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tct_pkg::COUNT_W-1:0] csr_token_limit
);
   import tct_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;

   // scan state and limit register
   state_type          state_ff, state_next;
   logic [COUNT_W-1:0] limit_ff;

   result_type [SLOTS-1:0] step_results;
   logic [SLOTS-1:0]       step_valid;
   result_type             rsp_data;
   logic                   can_load;
   logic                   move;      // byte leaves the input register this cycle
   logic                   req_take;

   assign move      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff && !rsp_valid;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         limit_ff    <= TOKEN_LIMIT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) begin
            state_ff <= state_next;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_token_limit;
         end
      end
   end

   // byte payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
   end

   tct_step #(
      .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
   ) u_step (
      .cur_state    (state_ff),
      .data_byte    (in_byte_ff),
      .final_byte   (in_final_ff),
      .token_limit  (limit_ff),
      .next_state   (state_next),
      .results      (step_results),
      .result_valid (step_valid)
   );

   tct_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (move),
      .results         (step_results),
      .result_valid    (step_valid),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign rsp_kind          = rsp_data.kind;
   assign rsp_char_code     = rsp_data.char_code;
   assign rsp_start_offset  = rsp_data.start_offset;
   assign rsp_end_offset    = rsp_data.end_offset;
   assign rsp_line_no       = rsp_data.line_no;
   assign rsp_column_no     = rsp_data.column_no;
   assign rsp_token_index   = rsp_data.token_index;
   assign rsp_is_end_record = rsp_data.is_end_record;

   `TCT_ASSERT_ALWAYS(a_reset_empties, reset |=> (!in_valid_ff && !rsp_valid))
   `TCT_ASSERT(a_stall_needs_byte, req_stall |-> in_valid_ff)
   `TCT_ASSERT(a_line_col_nonzero, (state_ff.line != '0) && (state_ff.col != '0) && (state_ff.esc_col != '0))
   `TCT_ASSERT(a_final_restarts, (move && in_final_ff) |=> ((state_ff.tok == '0) && (state_ff.mode == MODE_NORMAL)))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the catcode tokenizer: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;
   import tct_pkg::*;

   // A small stream cap keeps the saturation bound small.
   localparam int unsigned STREAM_CAP = 256;
   localparam logic [COUNT_W-1:0] SAT_LIMIT =
      (STREAM_CAP < 32'h1FFFFFF) ? STREAM_CAP[COUNT_W-1:0] : 25'h1FFFFFF;
   // Cycles to wait after the last expected record. Bytes that make no record
   // can still be in the input or scan register.
   localparam int DRAIN_CYCLES = 8;
   // Watchdog: cycles in a row with no transfer on any channel.
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 64;

   // One expected token record, with the fields in port order.
   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         char_code;
      logic [COUNT_W-1:0] start_offset;
      logic [COUNT_W-1:0] end_offset;
      logic [COUNT_W-1:0] line_no;
      logic [COUNT_W-1:0] column_no;
      logic [COUNT_W-1:0] token_index;
      logic               is_end_record;
      logic               last_of_run;
   } token_rec_t;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_final_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_kind;
   logic [7:0]         rsp_char_code;
   logic [COUNT_W-1:0] rsp_start_offset;
   logic [COUNT_W-1:0] rsp_end_offset;
   logic [COUNT_W-1:0] rsp_line_no;
   logic [COUNT_W-1:0] rsp_column_no;
   logic [COUNT_W-1:0] rsp_token_index;
   logic               rsp_is_end_record;
   logic               rsp_last_of_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_token_limit;

   tex_catcode_tokenizer #(.MAX_STREAM_BYTES(STREAM_CAP)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_char_code     (rsp_char_code),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_end_offset    (rsp_end_offset),
      .rsp_line_no       (rsp_line_no),
      .rsp_column_no     (rsp_column_no),
      .rsp_token_index   (rsp_token_index),
      .rsp_is_end_record (rsp_is_end_record),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_token_limit   (csr_token_limit)
   );

   always #6 clock = ~clock;

   // Predicted scanner state, updated at each accepted byte transfer.
   mode_type           cur_mode;
   logic [COUNT_W-1:0] cur_off;
   logic [COUNT_W-1:0] cur_line;
   logic [COUNT_W-1:0] cur_col;
   logic [COUNT_W-1:0] esc_off;
   logic [COUNT_W-1:0] esc_col;
   logic [COUNT_W-1:0] tok_count;
   logic [COUNT_W-1:0] tok_limit;

   // Records made by the byte being predicted, then queued in order.
   token_rec_t step_recs [0:MAX_RESULTS-1];
   int         step_n;
   token_rec_t pending_tokens [$];

   int errors = 0;
   int bytes_sent = 0;
   int streams_done = 0;
   int records_checked = 0;
   int limit_writes = 0;
   int idle_pct = 0;        // chance per cycle that the sender sits idle
   int stall_pct = 0;       // chance per cycle that the receiver stalls
   bit holdoff_req = 1'b0;  // asks the receiver for one long stall

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v < SAT_LIMIT) ? v + 1'b1 : v;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
             ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
   endfunction

   task automatic clear_stream();
      cur_mode  = MODE_NORMAL;
      cur_off   = '0;
      cur_line  = 25'd1;
      cur_col   = 25'd1;
      esc_off   = '0;
      esc_col   = 25'd1;
      tok_count = '0;
   endtask

   task automatic advance_pos();
      cur_off = sat_inc(cur_off);
      cur_col = sat_inc(cur_col);
   endtask

   task automatic add_rec(input logic [3:0] kind, input logic [7:0] code,
                          input logic [COUNT_W-1:0] s, input logic [COUNT_W-1:0] e,
                          input logic [COUNT_W-1:0] line, input logic [COUNT_W-1:0] col,
                          input logic [COUNT_W-1:0] idx, input logic end_rec);
      step_recs[step_n] = '{kind, code, s, e, line, col, idx, end_rec, 1'b0};
      step_n++;
   endtask

   // A counted token; reaching the limit stops the stream.
   task automatic add_token(input logic [3:0] kind, input logic [7:0] code,
                            input logic [COUNT_W-1:0] s, input logic [COUNT_W-1:0] e,
                            input logic [COUNT_W-1:0] col);
      add_rec(kind, code, s, e, cur_line, col, tok_count, 1'b0);
      tok_count = tok_count + 1'b1;
      if (tok_count >= tok_limit) cur_mode = MODE_STOPPED;
   endtask

   task automatic close_escape();
      cur_mode = MODE_NORMAL;
      add_token(KIND_ESCAPE, CH_NUL, esc_off, cur_off, esc_col);
   endtask

   // A byte read in normal mode.
   task automatic scan_plain(input logic [7:0] b);
      logic [3:0] kind;
      if ((tok_count >= tok_limit) || (b == CH_NUL)) begin
         cur_mode = MODE_STOPPED;
      end else if (b == CH_BACKSLASH) begin
         esc_off = cur_off;
         esc_col = cur_col;
         advance_pos();
         cur_mode = MODE_ESCAPE;
      end else if (b == CH_PERCENT) begin
         advance_pos();
         cur_mode = MODE_COMMENT;
      end else if (b == CH_NEWLINE) begin
         add_token(KIND_NEWLINE, b, cur_off, sat_inc(cur_off), cur_col);
         cur_off  = sat_inc(cur_off);
         cur_line = sat_inc(cur_line);
         cur_col  = 25'd1;
      end else begin
         if (b == CH_LBRACE)                         kind = KIND_OPEN;
         else if (b == CH_RBRACE)                    kind = KIND_CLOSE;
         else if (b == CH_DOLLAR)                    kind = KIND_DOLLAR;
         else if ((b == CH_SPACE) || (b == CH_TAB))  kind = KIND_SPACE;
         else if (is_alpha(b))                       kind = KIND_LETTER;
         else                                        kind = KIND_OTHER;
         add_token(kind, b, cur_off, sat_inc(cur_off), cur_col);
         advance_pos();
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic fin);
      token_rec_t rec;
      step_n = 0;
      case (cur_mode)
         MODE_ESCAPE: begin
            if (is_alpha(b)) begin
               advance_pos();
            end else begin
               close_escape();
               if (cur_mode == MODE_NORMAL) scan_plain(b);
            end
         end
         MODE_COMMENT: begin
            if (b == CH_NEWLINE) begin
               cur_mode = MODE_NORMAL;
               scan_plain(b);
            end else begin
               advance_pos();
            end
         end
         MODE_NORMAL: scan_plain(b);
         default: ;
      endcase
      if (fin) begin
         if (cur_mode == MODE_ESCAPE) close_escape();
         add_rec(KIND_ESCAPE, CH_NUL, cur_off, cur_off, cur_line, cur_col, tok_count, 1'b1);
         clear_stream();
         streams_done++;
      end
      for (int i = 0; i < step_n; i++) begin
         rec = step_recs[i];
         rec.last_of_run = (i == step_n - 1);
         pending_tokens.push_back(rec);
      end
      bytes_sent++;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, or one long hold-off counted here
   // ------------------------------------------------------------------
   int holdoff_left = 0;
   always @(posedge clock) begin
      if (holdoff_req) begin
         holdoff_req = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Checker: every record transfer against the oldest expectation
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      token_rec_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("token record with nothing expected: kind %0d char %0d index %0d",
                   rsp_kind, rsp_char_code, rsp_token_index);
            errors++;
         end else begin
            want = pending_tokens.pop_front();
            check_field("kind", COUNT_W'(want.kind), COUNT_W'(rsp_kind));
            check_field("char_code", COUNT_W'(want.char_code), COUNT_W'(rsp_char_code));
            check_field("start_offset",  want.start_offset,  rsp_start_offset);
            check_field("end_offset",    want.end_offset,    rsp_end_offset);
            check_field("line_no",       want.line_no,       rsp_line_no);
            check_field("column_no",     want.column_no,     rsp_column_no);
            check_field("token_index",   want.token_index,   rsp_token_index);
            check_field("is_end_record", COUNT_W'(want.is_end_record),
                        COUNT_W'(rsp_is_end_record));
            check_field("last_of_run", COUNT_W'(want.last_of_run),
                        COUNT_W'(rsp_last_of_run));
            records_checked++;
         end
      end
   end

   // Watchdog: a run that stops moving ends as a failure.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d records outstanding",
                  quiet_cycles, pending_tokens.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Offer one byte, hold it until the transfer, then maybe go idle.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      predict_byte(b, fin);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Quiesce: no byte offered, all records back, scan pipe empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_token_limit(input logic [COUNT_W-1:0] value);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_token_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tok_limit = value;
      limit_writes++;
   endtask

   // Mostly TeX-like text; twelve bytes in a hundred are fully random.
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30)      return $urandom_range(1) ? 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
                                                : 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      else if (r < 40) return CH_BACKSLASH;
      else if (r < 48) return $urandom_range(1) ? CH_SPACE : CH_TAB;
      else if (r < 52) return CH_LBRACE;
      else if (r < 56) return CH_RBRACE;
      else if (r < 60) return CH_DOLLAR;
      else if (r < 70) return CH_NEWLINE;
      else if (r < 75) return CH_PERCENT;
      else if (r < 78) return CH_NUL;
      else if (r < 88) return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      else             return 8'($urandom_range(255));
   endfunction

   // Random streams; the last byte always ends a stream.
   task automatic send_random_bytes(input int count);
      for (int i = 0; i < count; i++)
         send_byte(pick_byte(), (i == count - 1) || ($urandom_range(11) == 0));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Every category but letter, escapes closed by a brace, a backslash or a newline, comment skipping.
   task automatic test_catcodes();
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte("a", 1'b0);
      send_byte("Z", 1'b0);
      send_byte(CH_LBRACE, 1'b0);     // closes the escape, then a token
      send_byte(CH_RBRACE, 1'b0);
      send_byte(CH_DOLLAR, 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_BACKSLASH, 1'b0);  // empty escape, a new one opens
      send_byte(CH_NEWLINE, 1'b0);    // closes it, then a newline token
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_NUL, 1'b0);        // skipped inside a comment
      send_byte(8'hFF, 1'b0);
      send_byte(CH_NEWLINE, 1'b0);    // ends the comment, still a token
      send_byte("7", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte("q", 1'b0);
      send_byte(CH_LBRACE, 1'b1);     // escape, brace and end record in one byte
   endtask

   // Zero byte stop, bytes ignored after it, escape open at stream end.
   task automatic test_stop_rules();
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte("x", 1'b0);
      send_byte(CH_NUL, 1'b0);        // closes the escape first, then stops
      send_byte("y", 1'b0);
      send_byte(CH_RBRACE, 1'b1);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte("b", 1'b1);           // final byte inside an escape
      send_byte(CH_NUL, 1'b1);        // stream of one zero byte
   endtask

   task automatic test_token_limit();
      write_token_limit('0);          // stops at the first byte
      send_byte("a", 1'b0);
      send_byte(CH_LBRACE, 1'b1);
      write_token_limit(25'd1);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte("a", 1'b0);
      send_byte(CH_SPACE, 1'b0);      // escape reaches the limit, space dropped
      send_byte("c", 1'b1);
      write_token_limit(25'd2);
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_NEWLINE, 1'b0);
      send_byte("x", 1'b0);
      send_byte("y", 1'b1);
      write_token_limit(25'hFFFFFF);
      send_random_bytes(6);
      write_token_limit(TOKEN_LIMIT_RESET);
   endtask

   // Receiver holds off while bytes keep coming, so the input must stall.
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      holdoff_req = 1'b1;
      for (int i = 0; i < 20; i++)
         send_byte($urandom_range(1) ? CH_DOLLAR
                                     : 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)),
                   i == 19);
      wait_drained();
   endtask

   // Four idle/stall mixes, each with its own token limit.
   task automatic test_random_traffic();
      int idle_mix [4]  = '{0, 69, 0, 35};
      int stall_mix [4] = '{0, 0, 69, 35};
      logic [COUNT_W-1:0] limits [4];
      limits[0] = TOKEN_LIMIT_RESET;
      limits[1] = COUNT_W'($urandom_range(1, 6));
      limits[2] = COUNT_W'($urandom_range(2, 24));
      limits[3] = COUNT_W'($urandom_range(0, 3));
      for (int p = 0; p < 4; p++) begin
         write_token_limit(limits[p]);
         idle_pct  = idle_mix[p];
         stall_pct = stall_mix[p];
         send_random_bytes(10);
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   task automatic finish_run();
      wait_drained();
      $display("checked %0d token records from %0d bytes in %0d streams",
               records_checked, bytes_sent, streams_done);
      $display("%0d token limit writes from 0 to 2^24, four idle/stall mixes, one hold-off",
               limit_writes);
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= '0;
      req_final_byte  <= 1'b0;
      csr_valid       <= 1'b0;
      csr_token_limit <= '0;
      clear_stream();
      tok_limit = TOKEN_LIMIT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_catcodes();
      test_stop_rules();
      test_token_limit();
      test_backpressure();
      test_random_traffic();
      finish_run();
   end

endmodule

// File: sim.f
+incdir+design
design/tct_pkg.sv
design/tct_step.sv
design/tct_rsp_buf.sv
design/tex_catcode_tokenizer.sv
tb/sv/tb_top.sv
